[hw/rtl/srw_pkg.sv]
package srw_pkg;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_FRONT   = 3'd1,
    OP_SUCCESS = 3'd2,
    OP_FAILURE = 3'd3,
    OP_ADVANCE = 3'd4,
    OP_LEAD    = 3'd5,
    OP_FOLLOW  = 3'd6,
    OP_STOP    = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_STOPPED  = 4'd1,
    ST_INVALID  = 4'd2,
    ST_UNPOS    = 4'd3,
    ST_BELOW    = 4'd4,
    ST_BEYOND   = 4'd5,
    ST_DUP      = 4'd6,
    ST_MISSING  = 4'd7,
    ST_FULL     = 4'd8,
    ST_MISMATCH = 4'd9
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SEARCH,
    FSM_APPLY,
    FSM_OUT
  } fsm_e;

  localparam int unsigned PosW = 62;
  localparam int unsigned TagW = 16;
  localparam int unsigned ByteW = 32;

  // command broadcast to every cell
  typedef struct packed {
    logic            write;   // write payload and set used in the free target cell
    logic            retire;  // clear used in the hit cell
    logic            flush;   // clear used where start is below key
    logic            clear;   // clear every cell
    logic [PosW-1:0] key;
    logic [PosW-1:0] wr_start;
    logic [PosW-1:0] wr_end;
    logic [TagW-1:0] wr_tag;
  } cell_cmd_t;

  // flags that ripple down the chain
  typedef struct packed {
    logic            hit;
    logic            free;
    logic            taken;   // write already claimed by an earlier cell
    logic [PosW-1:0] hit_start;
    logic [PosW-1:0] hit_end;
    logic [TagW-1:0] hit_tag;
  } cell_chain_t;

endpackage

[hw/rtl/sequence_reorder_window_core.sv]
// after an input transfer the core steps through search, apply and out; the result is valid in out
// the cell chain search and the apply step each have their own state
// the input waits until the previous result transfer has happened
// reset: table empty, position and mark unset, window register 67108864, not stopped
// flush and clear act on all cells in parallel in the apply state; flushed bytes are summed
// per group in the search cycle and across groups in the apply cycle
module sequence_reorder_window_core #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [61:0] start_pos_i,
  input  logic [61:0] end_pos_i,
  input  logic [61:0] stamp_i,
  input  logic [15:0] payload_tag_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  status_o,
  output logic [61:0] entry_start_o,
  output logic [61:0] entry_end_o,
  output logic [15:0] entry_tag_o,
  output logic [61:0] next_pos_o,
  output logic        next_valid_o,
  output logic [61:0] ack_pos_o,
  output logic [61:0] ack_stamp_o,
  output logic [31:0] held_bytes_o,
  output logic [$clog2(TABLE_ENTRIES+1)-1:0] entry_count_o
);

  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned PosW = srw_pkg::PosW;
  localparam int unsigned ByteW = srw_pkg::ByteW;
  localparam int unsigned GrpLen = 8;
  localparam int unsigned Grps = (TABLE_ENTRIES + GrpLen - 1) / GrpLen;

  // configuration
  logic [31:0] win_q;
  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? win_q : '0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= 32'd67108864;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      win_q <= pwdata;
    end
  end

  srw_pkg::fsm_e state_q, state_d;
  logic          busy_q, busy_d;

  logic [2:0]      op_q;
  logic [PosW-1:0] s_q, e_q, stamp_q;
  logic [15:0]     tag_q;

  logic [PosW-1:0]  pos_q, mark_q, mstamp_q;
  logic             pset_q, mset_q, stop_q;
  logic [ByteW-1:0] held_q;

  // search results
  logic             hit_q, free_q;
  logic [PosW-1:0]  hs_q, he_q;
  logic [15:0]      ht_q;
  logic [srw_pkg::PosW-1:0] key_now;

  srw_pkg::cell_cmd_t   cmd;
  srw_pkg::cell_chain_t chain [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] used_v;
  logic [ByteW-1:0] fb [TABLE_ENTRIES];
  logic [ByteW-1:0] part_d [Grps];
  logic [ByteW-1:0] part_q [Grps];
  logic [ByteW-1:0] fsum;
  logic [CntW-1:0]  used_cnt;

  // result staging
  logic             ov_q;
  logic [3:0]       st_q;
  logic [PosW-1:0]  es_q, ee_q;
  logic [15:0]      et_q;

  assign in_ready_o = (state_q == srw_pkg::FSM_IDLE);
  wire in_xfer = in_valid_i && in_ready_o;

  assign key_now = (op_q == srw_pkg::OP_ADVANCE) ? e_q :
                   (op_q == srw_pkg::OP_FRONT) ? pos_q : s_q;

  // status decision (valid in APPLY using searched flags)
  logic [3:0] status;
  logic       adv_go;
  always_comb begin
    status = srw_pkg::ST_OK;
    adv_go = 1'b0;
    unique case (srw_pkg::op_e'(op_q))
      srw_pkg::OP_PUSH: begin
        if (stop_q) status = srw_pkg::ST_STOPPED;
        else if (e_q <= s_q) status = srw_pkg::ST_INVALID;
        else if (!pset_q) status = srw_pkg::ST_UNPOS;
        else if (s_q < pos_q) status = srw_pkg::ST_BELOW;
        else if ((e_q - pos_q) > {30'd0, win_q}) status = srw_pkg::ST_BEYOND;
        else if (hit_q) status = srw_pkg::ST_DUP;
        else if (!free_q) status = srw_pkg::ST_FULL;
      end
      srw_pkg::OP_FRONT: begin
        if (stop_q) status = srw_pkg::ST_STOPPED;
        else if (!pset_q) status = srw_pkg::ST_UNPOS;
        else if (!hit_q) status = srw_pkg::ST_MISSING;
      end
      srw_pkg::OP_SUCCESS: begin
        if (stop_q) status = srw_pkg::ST_STOPPED;
        else if (e_q <= s_q) status = srw_pkg::ST_INVALID;
        else if (!pset_q) status = srw_pkg::ST_UNPOS;
        else if (s_q != pos_q) status = srw_pkg::ST_MISMATCH;
      end
      srw_pkg::OP_FAILURE: begin
        if (stop_q) status = srw_pkg::ST_STOPPED;
        else if (e_q <= s_q) status = srw_pkg::ST_INVALID;
      end
      srw_pkg::OP_ADVANCE: begin
        if (stop_q) status = srw_pkg::ST_STOPPED;
        else if (!pset_q) status = srw_pkg::ST_UNPOS;
        else adv_go = (e_q > pos_q);
      end
      default: status = srw_pkg::ST_OK;
    endcase
  end

  wire apply = (state_q == srw_pkg::FSM_APPLY);
  wire ok    = (status == srw_pkg::ST_OK);

  always_comb begin
    cmd          = '0;
    cmd.key      = key_now;
    cmd.wr_start = s_q;
    cmd.wr_end   = e_q;
    cmd.wr_tag   = tag_q;
    if (apply) begin
      cmd.write  = ok && (op_q == srw_pkg::OP_PUSH);
      cmd.retire = ok && (op_q == srw_pkg::OP_SUCCESS);
      cmd.flush  = adv_go;
      cmd.clear  = (op_q == srw_pkg::OP_FOLLOW);
    end
  end

  assign chain[0] = '0;
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    srw_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .chain_i       (chain[g]),
      .chain_o       (chain[g+1]),
      .used_o        (used_v[g]),
      .flush_bytes_o (fb[g])
    );
  end

  // occupied cell count
  always_comb begin
    used_cnt = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      used_cnt = used_cnt + CntW'(used_v[i]);
    end
  end

  // bytes below the key, one partial sum per group of cells
  always_comb begin
    for (int g = 0; g < Grps; g++) begin
      part_d[g] = '0;
      for (int j = 0; j < GrpLen; j++) begin
        if (g * GrpLen + j < TABLE_ENTRIES) part_d[g] = part_d[g] + fb[g * GrpLen + j];
      end
    end
  end

  always_comb begin
    fsum = '0;
    for (int g = 0; g < Grps; g++) begin
      fsum = fsum + part_q[g];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srw_pkg::FSM_IDLE:   if (in_xfer) state_d = srw_pkg::FSM_SEARCH;
      srw_pkg::FSM_SEARCH: state_d = srw_pkg::FSM_APPLY;
      srw_pkg::FSM_APPLY:  state_d = srw_pkg::FSM_OUT;
      srw_pkg::FSM_OUT:    if (!ov_q || out_ready_i) state_d = srw_pkg::FSM_IDLE;
      default:             state_d = srw_pkg::FSM_IDLE;
    endcase
  end
  assign busy_d = (state_d != srw_pkg::FSM_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srw_pkg::FSM_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q    <= operation_i;
      s_q     <= start_pos_i;
      e_q     <= end_pos_i;
      stamp_q <= stamp_i;
      tag_q   <= payload_tag_i;
    end
    if (state_q == srw_pkg::FSM_SEARCH) begin
      hit_q <= chain[TABLE_ENTRIES].hit;
      free_q <= chain[TABLE_ENTRIES].free;
      hs_q  <= chain[TABLE_ENTRIES].hit_start;
      he_q  <= chain[TABLE_ENTRIES].hit_end;
      ht_q  <= chain[TABLE_ENTRIES].hit_tag;
      for (int g = 0; g < Grps; g++) begin
        part_q[g] <= part_d[g];
      end
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      pset_q   <= 1'b0;
      mark_q   <= '0;
      mset_q   <= 1'b0;
      mstamp_q <= '0;
      held_q   <= '0;
      stop_q   <= 1'b0;
    end else begin
      if (apply) begin
        unique case (srw_pkg::op_e'(op_q))
          srw_pkg::OP_PUSH: if (ok) begin
            held_q <= held_q + e_q[ByteW-1:0] - s_q[ByteW-1:0];
            if (mset_q && e_q > mark_q) begin
              mark_q   <= e_q;
              mstamp_q <= stamp_q;
            end
          end
          srw_pkg::OP_SUCCESS: if (ok) begin
            held_q <= held_q - (e_q[ByteW-1:0] - s_q[ByteW-1:0]);
            pos_q  <= e_q;
          end
          srw_pkg::OP_ADVANCE: if (adv_go) begin
            pos_q  <= e_q;
            held_q <= held_q - fsum;
          end
          srw_pkg::OP_LEAD: begin
            pos_q    <= e_q;
            pset_q   <= 1'b1;
            mark_q   <= e_q;
            mset_q   <= 1'b1;
            mstamp_q <= '0;
          end
          srw_pkg::OP_FOLLOW: begin
            pos_q    <= '0;
            pset_q   <= 1'b0;
            mark_q   <= '0;
            mset_q   <= 1'b0;
            mstamp_q <= '0;
            held_q   <= '0;
          end
          srw_pkg::OP_STOP: stop_q <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (apply) begin
      ov_q <= 1'b1;
    end else if (ov_q && out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply) begin
      st_q <= status;
      if (ok && op_q == srw_pkg::OP_FRONT) begin
        es_q <= hs_q;
        ee_q <= he_q;
        et_q <= ht_q;
      end else begin
        es_q <= '0;
        ee_q <= '0;
        et_q <= '0;
      end
    end
  end

  assign out_valid_o    = ov_q && (state_q == srw_pkg::FSM_OUT);
  assign status_o       = st_q;
  assign entry_start_o  = es_q;
  assign entry_end_o    = ee_q;
  assign entry_tag_o    = et_q;
  assign next_pos_o     = pset_q ? pos_q : '0;
  assign next_valid_o   = pset_q;
  assign ack_pos_o      = mset_q ? mark_q : '0;
  assign ack_stamp_o    = mstamp_q;
  assign held_bytes_o   = held_q;
  assign entry_count_o  = used_cnt;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == srw_pkg::FSM_OUT))
    else $error("result shown outside output state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> !busy_q)
    else $error("input taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (apply && op_q == srw_pkg::OP_FOLLOW) |=> (entry_count_o == '0))
    else $error("follow left entries");

endmodule

[hw/rtl/srw_cell.sv]
module srw_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srw_pkg::cell_cmd_t   cmd_i,
  input  srw_pkg::cell_chain_t chain_i,
  output srw_pkg::cell_chain_t chain_o,
  output logic                used_o,
  output logic [srw_pkg::ByteW-1:0] flush_bytes_o
);

  logic                      used_q, used_d;
  logic [srw_pkg::PosW-1:0]  start_q;
  logic [srw_pkg::PosW-1:0]  end_q;
  logic [srw_pkg::TagW-1:0]  tag_q;
  logic                      match, below, claim;
  logic [srw_pkg::PosW-1:0]  size;

  assign match = used_q && (start_q == cmd_i.key);
  assign below = used_q && (start_q < cmd_i.key);
  assign claim = !used_q && !chain_i.taken;
  assign size  = end_q - start_q;

  always_comb begin
    chain_o = chain_i;
    if (match && !chain_i.hit) begin
      chain_o.hit       = 1'b1;
      chain_o.hit_start = start_q;
      chain_o.hit_end   = end_q;
      chain_o.hit_tag   = tag_q;
    end
    if (!used_q) begin
      chain_o.free  = 1'b1;
      chain_o.taken = 1'b1;
    end
  end

  // bytes this cell gives up if the key becomes the new position
  assign flush_bytes_o = below ? size[srw_pkg::ByteW-1:0] : '0;
  assign used_o = used_q;

  always_comb begin
    used_d = used_q;
    if (cmd_i.clear) begin
      used_d = 1'b0;
    end else if (cmd_i.write && claim) begin
      used_d = 1'b1;
    end else if (cmd_i.retire && match && !chain_i.hit) begin
      used_d = 1'b0;
    end else if (cmd_i.flush && below) begin
      used_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && claim && !cmd_i.clear) begin
      start_q <= cmd_i.wr_start;
      end_q   <= cmd_i.wr_end;
      tag_q   <= cmd_i.wr_tag;
    end
  end

endmodule

[verif/sequence_reorder_window_core_tb.sv]
module sequence_reorder_window_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots = 64;
  localparam logic [61:0] PosMax = {62{1'b1}};

  typedef struct {
    srw_pkg::status_e status;
    logic [61:0] entry_start;
    logic [61:0] entry_end;
    logic [15:0] entry_tag;
    logic [61:0] next_pos;
    logic        next_valid;
    logic [61:0] ack_pos;
    logic [61:0] ack_stamp;
    logic [31:0] held_bytes;
    logic [6:0]  entry_count;
  } result_t;

  typedef struct {
    srw_pkg::op_e     op;
    logic [61:0]      s;
    logic [61:0]      e;
    logic [61:0]      stamp;
    logic [15:0]      tag;
    bit               fixed;
    srw_pkg::status_e st;
  } row_t;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [0:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [2:0]  operation_i = '0;
  logic [61:0] start_pos_i = '0, end_pos_i = '0, stamp_i = '0;
  logic [15:0] payload_tag_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [3:0]  status_o;
  logic [61:0] entry_start_o, entry_end_o, next_pos_o, ack_pos_o, ack_stamp_o;
  logic [15:0] entry_tag_o;
  logic        next_valid_o;
  logic [31:0] held_bytes_o;
  logic [6:0]  entry_count_o;

  sequence_reorder_window_core dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // shadow of the reorder table
  bit          sh_used[Slots];
  logic [61:0] sh_start[Slots];
  logic [61:0] sh_end[Slots];
  logic [15:0] sh_tag[Slots];
  logic [61:0] sh_next;
  bit          sh_pos_set;
  logic [61:0] sh_mark;
  bit          sh_mark_set;
  logic [61:0] sh_mark_stamp;
  logic [31:0] sh_held;
  bit          sh_stopped;
  logic [31:0] sh_window = 32'd67108864;

  logic [31:0] windows[4] = '{32'd67108864, 32'hffffffff, 32'd1, 32'd400};

  result_t pending_results[$];
  int      errors = 0;
  bit      calm = 0;
  int      out_stall = 0;

  function automatic int slot_of(logic [61:0] key);
    for (int i = 0; i < Slots; i++) if (sh_used[i] && sh_start[i] == key) return i;
    return -1;
  endfunction

  function automatic result_t predict_segment(srw_pkg::op_e op, logic [61:0] s,
                                              logic [61:0] e, logic [61:0] stamp,
                                              logic [15:0] tag);
    result_t r;
    int k;
    int n;
    r.status = srw_pkg::ST_OK;
    r.entry_start = '0;
    r.entry_end = '0;
    r.entry_tag = '0;
    case (op)
      srw_pkg::OP_PUSH: begin
        if (sh_stopped) r.status = srw_pkg::ST_STOPPED;
        else if (e <= s) r.status = srw_pkg::ST_INVALID;
        else if (!sh_pos_set) r.status = srw_pkg::ST_UNPOS;
        else if (s < sh_next) r.status = srw_pkg::ST_BELOW;
        else if (e - sh_next > {30'd0, sh_window}) r.status = srw_pkg::ST_BEYOND;
        else if (slot_of(s) >= 0) r.status = srw_pkg::ST_DUP;
        else begin
          k = -1;
          for (int i = Slots - 1; i >= 0; i--) if (!sh_used[i]) k = i;
          if (k < 0) r.status = srw_pkg::ST_FULL;
          else begin
            sh_used[k] = 1;
            sh_start[k] = s;
            sh_end[k] = e;
            sh_tag[k] = tag;
            sh_held = sh_held + 32'(e - s);
            if (sh_mark_set && e > sh_mark) begin
              sh_mark = e;
              sh_mark_stamp = stamp;
            end
          end
        end
      end
      srw_pkg::OP_FRONT: begin
        if (sh_stopped) r.status = srw_pkg::ST_STOPPED;
        else if (!sh_pos_set) r.status = srw_pkg::ST_UNPOS;
        else begin
          k = slot_of(sh_next);
          if (k < 0) r.status = srw_pkg::ST_MISSING;
          else begin
            r.entry_start = sh_start[k];
            r.entry_end = sh_end[k];
            r.entry_tag = sh_tag[k];
          end
        end
      end
      srw_pkg::OP_SUCCESS: begin
        if (sh_stopped) r.status = srw_pkg::ST_STOPPED;
        else if (e <= s) r.status = srw_pkg::ST_INVALID;
        else if (!sh_pos_set) r.status = srw_pkg::ST_UNPOS;
        else if (s != sh_next) r.status = srw_pkg::ST_MISMATCH;
        else begin
          sh_held = sh_held - 32'(e - s);
          sh_next = e;
          k = slot_of(s);
          if (k >= 0) sh_used[k] = 0;
        end
      end
      srw_pkg::OP_FAILURE: begin
        if (sh_stopped) r.status = srw_pkg::ST_STOPPED;
        else if (e <= s) r.status = srw_pkg::ST_INVALID;
      end
      srw_pkg::OP_ADVANCE: begin
        if (sh_stopped) r.status = srw_pkg::ST_STOPPED;
        else if (!sh_pos_set) r.status = srw_pkg::ST_UNPOS;
        else if (e > sh_next) begin
          sh_next = e;
          for (int i = 0; i < Slots; i++)
            if (sh_used[i] && sh_start[i] < e) begin
              sh_used[i] = 0;
              sh_held = sh_held - 32'(sh_end[i] - sh_start[i]);
            end
        end
      end
      srw_pkg::OP_LEAD: begin
        sh_next = e;
        sh_pos_set = 1;
        sh_mark = e;
        sh_mark_set = 1;
        sh_mark_stamp = '0;
      end
      srw_pkg::OP_FOLLOW: begin
        sh_next = '0;
        sh_pos_set = 0;
        sh_mark = '0;
        sh_mark_set = 0;
        sh_mark_stamp = '0;
        sh_held = '0;
        for (int i = 0; i < Slots; i++) sh_used[i] = 0;
      end
      default: sh_stopped = 1;
    endcase
    n = 0;
    for (int i = 0; i < Slots; i++) n += sh_used[i];
    r.next_pos = sh_pos_set ? sh_next : '0;
    r.next_valid = sh_pos_set;
    r.ack_pos = sh_mark_set ? sh_mark : '0;
    r.ack_stamp = sh_mark_stamp;
    r.held_bytes = sh_held;
    r.entry_count = 7'(n);
    return r;
  endfunction

  // one input transfer; valid stays up after return unless the task inserts a random idle gap
  task automatic send_segment(srw_pkg::op_e op, logic [61:0] s, logic [61:0] e,
                              logic [61:0] stamp, logic [15:0] tag, bit fixed = 0,
                              srw_pkg::status_e st = srw_pkg::ST_OK);
    result_t r;
    in_valid_i <= 1;
    operation_i <= op;
    start_pos_i <= s;
    end_pos_i <= e;
    stamp_i <= stamp;
    payload_tag_i <= tag;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    r = predict_segment(op, s, e, stamp, tag);
    if (fixed) r.status = st;
    pending_results.push_back(r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_window(logic [31:0] value);
    drain_results();
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= '0;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sh_window = value;
    @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (!calm && out_stall > 0) begin
      out_ready_i <= 0;
      out_stall <= out_stall - 1;
    end else begin
      out_ready_i <= 1;
      if (!calm && $urandom_range(0, 7) == 0) out_stall <= $urandom_range(1, 5);
    end
  end

  always @(posedge clk_i) begin
    result_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer, status %0d", $realtime, status_o);
      end else begin
        w = pending_results.pop_front();
        check_field("status", 64'(w.status), 64'(status_o));
        check_field("entry_start", 64'(w.entry_start), 64'(entry_start_o));
        check_field("entry_end", 64'(w.entry_end), 64'(entry_end_o));
        check_field("entry_tag", 64'(w.entry_tag), 64'(entry_tag_o));
        check_field("next_pos", 64'(w.next_pos), 64'(next_pos_o));
        check_field("next_valid", 64'(w.next_valid), 64'(next_valid_o));
        check_field("ack_pos", 64'(w.ack_pos), 64'(ack_pos_o));
        check_field("ack_stamp", 64'(w.ack_stamp), 64'(ack_stamp_o));
        check_field("held_bytes", 64'(w.held_bytes), 64'(held_bytes_o));
        check_field("entry_count", 64'(w.entry_count), 64'(entry_count_o));
      end
    end
  end

  function automatic logic [61:0] rand62();
    return 62'({$urandom, $urandom});
  endfunction

  task automatic random_segment();
    int pick;
    int k;
    logic [61:0] s, e;
    pick = $urandom_range(0, 99);
    s = sh_next + $urandom_range(0, 300);
    e = s + $urandom_range(1, 64);
    if (pick < 45) begin
      if ($urandom_range(0, 9) == 0) begin
        s = rand62();
        e = rand62();
      end
      send_segment(srw_pkg::OP_PUSH, s, e, rand62(), 16'($urandom));
    end else if (pick < 58) begin
      send_segment(srw_pkg::OP_FRONT, rand62(), rand62(), rand62(), 16'($urandom));
    end else if (pick < 75) begin
      k = slot_of(sh_next);
      s = sh_next;
      e = (k >= 0) ? sh_end[k] : sh_next + $urandom_range(1, 64);
      if ($urandom_range(0, 7) == 0) s = rand62();
      send_segment(srw_pkg::OP_SUCCESS, s, e, rand62(), 16'($urandom));
    end else if (pick < 82) begin
      send_segment(srw_pkg::OP_FAILURE, rand62() >> $urandom_range(0, 61), rand62(),
                   rand62(), 16'($urandom));
    end else if (pick < 92) begin
      e = sh_next + $urandom_range(0, 200) - 20;
      send_segment(srw_pkg::OP_ADVANCE, s, e, rand62(), 16'($urandom));
    end else if (pick < 98 || !sh_pos_set) begin
      e = ($urandom_range(0, 3) == 0) ? rand62() : 62'($urandom_range(0, 100000));
      if (e > PosMax - 100000) e = e - 100000;
      send_segment(srw_pkg::OP_LEAD, rand62(), e, rand62(), 16'($urandom));
    end else begin
      send_segment(srw_pkg::OP_FOLLOW, rand62(), rand62(), rand62(), 16'($urandom));
    end
  endtask

  row_t opening_rows[] = '{
    '{srw_pkg::OP_FRONT, 0, 0, 0, 0, 1, srw_pkg::ST_UNPOS},
    '{srw_pkg::OP_PUSH, 5, 5, 0, 0, 1, srw_pkg::ST_INVALID},
    '{srw_pkg::OP_PUSH, 0, 10, 0, 0, 1, srw_pkg::ST_UNPOS},
    '{srw_pkg::OP_ADVANCE, 0, 50, 0, 0, 1, srw_pkg::ST_UNPOS},
    '{srw_pkg::OP_SUCCESS, 0, 10, 0, 0, 1, srw_pkg::ST_UNPOS},
    '{srw_pkg::OP_FAILURE, 10, 3, 0, 0, 1, srw_pkg::ST_INVALID},
    '{srw_pkg::OP_FAILURE, 3, 10, 0, 0, 1, srw_pkg::ST_OK},
    '{srw_pkg::OP_LEAD, 0, 100, 0, 0, 1, srw_pkg::ST_OK},
    '{srw_pkg::OP_PUSH, 90, 120, 7, 1, 1, srw_pkg::ST_BELOW},
    '{srw_pkg::OP_PUSH, 100, 120, PosMax, 16'hffff, 1, srw_pkg::ST_OK},
    '{srw_pkg::OP_PUSH, 100, 130, 5, 2, 1, srw_pkg::ST_DUP},
    '{srw_pkg::OP_PUSH, 200, 100 + 67108865, 5, 3, 1, srw_pkg::ST_BEYOND},
    '{srw_pkg::OP_PUSH, 200, 100 + 67108864, 9, 4, 1, srw_pkg::ST_OK},
    '{srw_pkg::OP_FRONT, 0, 0, 0, 0, 0, srw_pkg::ST_OK},
    '{srw_pkg::OP_SUCCESS, 150, 160, 0, 0, 1, srw_pkg::ST_MISMATCH},
    '{srw_pkg::OP_SUCCESS, 100, 120, 0, 0, 1, srw_pkg::ST_OK},
    '{srw_pkg::OP_FRONT, 0, 0, 0, 0, 1, srw_pkg::ST_MISSING},
    '{srw_pkg::OP_ADVANCE, 0, 50, 0, 0, 1, srw_pkg::ST_OK},
    '{srw_pkg::OP_ADVANCE, 0, 300, 0, 0, 1, srw_pkg::ST_OK},
    '{srw_pkg::OP_LEAD, 0, PosMax - 10, 0, 0, 1, srw_pkg::ST_OK},
    '{srw_pkg::OP_PUSH, PosMax - 10, PosMax, 62'h2aaa_aaaa_aaaa_aaaa, 16'h5555, 1,
      srw_pkg::ST_OK},
    '{srw_pkg::OP_FRONT, 0, 0, 0, 0, 0, srw_pkg::ST_OK},
    '{srw_pkg::OP_FOLLOW, 0, 0, 0, 0, 1, srw_pkg::ST_OK},
    '{srw_pkg::OP_LEAD, 0, 0, 0, 0, 1, srw_pkg::ST_OK},
    '{srw_pkg::OP_SUCCESS, 0, 40, 0, 0, 1, srw_pkg::ST_OK}
  };

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    foreach (opening_rows[i])
      send_segment(opening_rows[i].op, opening_rows[i].s, opening_rows[i].e,
                   opening_rows[i].stamp, opening_rows[i].tag, opening_rows[i].fixed,
                   opening_rows[i].st);

    // fill the table past capacity
    send_segment(srw_pkg::OP_LEAD, '0, 62'd1000, '0, '0);
    for (int i = 0; i < Slots + 2; i++)
      send_segment(srw_pkg::OP_PUSH, 62'(1000 + 2 * i), 62'(1001 + 2 * i), rand62(),
                   16'($urandom));
    send_segment(srw_pkg::OP_ADVANCE, '0, 62'd1100, '0, '0);

    foreach (windows[w]) begin
      write_window(windows[w]);
      for (int i = 0; i < 180; i++) random_segment();
    end

    write_window(32'd67108864);
    calm = 1;
    for (int i = 0; i < 60; i++) random_segment();
    send_segment(srw_pkg::OP_STOP, rand62(), rand62(), rand62(), 16'($urandom));
    for (int i = 0; i < 16; i++)
      send_segment(srw_pkg::op_e'(3'(i % 8)), rand62(), rand62(), rand62(), 16'($urandom));

    in_valid_i <= 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #4ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
